[src/cave_gen_pkg.sv]
`default_nettype none

package cave_gen_pkg;

  localparam int CFG_DATA_W  = 8;
  localparam int CFG_INDEX_W = 3;
  localparam int THRESH_W    = 4;
  localparam int COUNT_W     = 4;

  localparam int RESET_BIRTH_MIN  = 6;
  localparam int RESET_DEATH_MAX  = 3;
  localparam int RESET_ROW_LENGTH = 100;
  localparam int RESET_ROW_COUNT  = 100;
  localparam int MIN_GEOMETRY     = 2;

  // Output queue: holds results while the consumer stalls
  localparam int OBUF_DEPTH = 3;
  localparam int OBUF_PTR_W = 2;
  localparam int OBUF_CNT_W = 2;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_BIRTH_MIN  = 3'd0,
    REG_DEATH_MAX  = 3'd1,
    REG_ROW_LENGTH = 3'd2,
    REG_ROW_COUNT  = 3'd3
  } cfg_reg_t;

  // Item in the read-modify-write stage
  typedef struct packed {
    logic valid;
    logic alive;
    logic emit;
    logic last;
    logic at_left;
    logic at_right;
    logic at_top;
    logic at_bottom;
  } s1_flags_t;

  typedef struct packed {
    logic new_alive;
    logic last_cell;
  } result_t;

endpackage

`default_nettype wire

[src/cave_gen_ram.sv]
`default_nettype none

module cave_gen_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

[src/cave_gen_seq.sv]
`default_nettype none

module cave_gen_seq
  import cave_gen_pkg::*;
#(
  parameter int MAX_ROW_LENGTH = 128,
  parameter int MAX_ROW_COUNT  = 128
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              restart,
  input  logic                              take,
  input  logic                              cell_alive,
  input  logic                              flush,
  input  logic [$clog2(MAX_ROW_LENGTH)-1:0] len_m1,
  input  logic [$clog2(MAX_ROW_COUNT)-1:0]  rows_m1,
  output logic [$clog2(MAX_ROW_LENGTH)-1:0] rd_col,
  output logic [$clog2(MAX_ROW_LENGTH)-1:0] s1_col,
  output s1_flags_t                         s1
);

  localparam int CW  = $clog2(MAX_ROW_LENGTH);
  localparam int RCW = $clog2(MAX_ROW_COUNT);
  // input row runs past the grid by the tail of one row plus one cell
  localparam int RW  = $clog2(MAX_ROW_COUNT + 2);

  logic [CW-1:0]  in_col, in_col_next;
  logic [RW-1:0]  in_row, in_row_next;
  logic [CW-1:0]  out_col, out_col_next;
  logic [RCW-1:0] out_row, out_row_next;
  logic           grid_done, step, emit, last_out, in_wrap, out_wrap;
  s1_flags_t      s1_next;

  assign rd_col = in_col;

  always_comb begin
    grid_done = in_row > RW'(rows_m1);
    // flush before the grid is complete is dropped
    step      = take && !(flush && !grid_done);
    emit      = (in_row > RW'(1)) || ((in_row == RW'(1)) && (in_col != '0));
    in_wrap   = in_col == len_m1;
    out_wrap  = out_col == len_m1;
    last_out  = emit && (out_row == rows_m1) && out_wrap;

    in_col_next  = in_col;
    in_row_next  = in_row;
    out_col_next = out_col;
    out_row_next = out_row;
    if (step) begin
      if (last_out) begin
        in_col_next  = '0;
        in_row_next  = '0;
        out_col_next = '0;
        out_row_next = '0;
      end else begin
        in_col_next = in_wrap ? '0 : in_col + CW'(1);
        if (in_wrap) begin
          in_row_next = in_row + RW'(1);
        end
        if (emit) begin
          out_col_next = out_wrap ? '0 : out_col + CW'(1);
          if (out_wrap) begin
            out_row_next = out_row + RCW'(1);
          end
        end
      end
    end

    s1_next.valid     = step;
    s1_next.alive     = cell_alive && !grid_done;
    s1_next.emit      = emit;
    s1_next.last      = last_out;
    s1_next.at_left   = out_col == '0;
    s1_next.at_right  = out_wrap;
    s1_next.at_top    = out_row == '0;
    s1_next.at_bottom = out_row == rows_m1;
  end

  always_ff @(posedge clk) begin
    if (rst || restart) begin
      in_col  <= '0;
      in_row  <= '0;
      out_col <= '0;
      out_row <= '0;
    end else begin
      in_col  <= in_col_next;
      in_row  <= in_row_next;
      out_col <= out_col_next;
      out_row <= out_row_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1 <= '0;
    end else begin
      s1 <= s1_next;
    end
    s1_col <= in_col;
  end

endmodule

`default_nettype wire

[src/cave_gen_cell.sv]
`default_nettype none

module cave_gen_cell
  import cave_gen_pkg::*;
#(
  parameter int MAX_ROW_LENGTH = 128
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              restart,
  input  s1_flags_t                         s1,
  input  logic [$clog2(MAX_ROW_LENGTH)-1:0] s1_col,
  input  logic [1:0]                        rd_data,
  input  logic [THRESH_W-1:0]               birth_min,
  input  logic [THRESH_W-1:0]               death_max,
  output logic                              wr_en,
  output logic [$clog2(MAX_ROW_LENGTH)-1:0] wr_addr,
  output logic [1:0]                        wr_data,
  output logic                              push,
  output result_t                           res
);

  localparam int CW = $clog2(MAX_ROW_LENGTH);

  // line entry: [1] row above, [0] two rows above
  logic [1:0]         line;
  logic [2:0]         column;
  logic [8:0]         window, win_new;
  logic [COUNT_W-1:0] count;
  logic               nb_on, center, next_alive;
  logic               fwd_valid;
  logic [CW-1:0]      fwd_col;
  logic [1:0]         fwd_data;

  always_comb begin
    // previous beat's write lands too late for a read of the same entry
    line    = (fwd_valid && (fwd_col == s1_col)) ? fwd_data : rd_data;
    column  = {s1.alive, line[1], line[0]};
    win_new = {window[5:0], column};

    count = '0;
    for (int k = 0; k < 3; k++) begin
      for (int j = 0; j < 3; j++) begin
        nb_on = !((k == 1) && (j == 1))
             && !((k == 0) && s1.at_left)
             && !((k == 2) && s1.at_right)
             && !((j == 0) && s1.at_top)
             && !((j == 2) && s1.at_bottom);
        if (nb_on) begin
          count = count + COUNT_W'(win_new[(2 - k) * 3 + j]);
        end
      end
    end

    center = win_new[4];
    if (!center && (count >= birth_min)) begin
      next_alive = 1'b1;
    end else if (center && (count <= death_max)) begin
      next_alive = 1'b0;
    end else begin
      next_alive = center;
    end
  end

  assign wr_en         = s1.valid;
  assign wr_addr       = s1_col;
  assign wr_data       = {s1.alive, line[1]};
  assign push          = s1.valid && s1.emit;
  assign res.new_alive = next_alive;
  assign res.last_cell = s1.last;

  always_ff @(posedge clk) begin
    if (rst || restart) begin
      window <= '0;
    end else if (s1.valid) begin
      window <= s1.last ? '0 : win_new;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_valid <= 1'b0;
    end else begin
      fwd_valid <= s1.valid;
    end
    fwd_col  <= s1_col;
    fwd_data <= wr_data;
  end

endmodule

`default_nettype wire

[src/cave_gen_obuf.sv]
`default_nettype none

module cave_gen_obuf
  import cave_gen_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  result_t wdata,
  input  logic    inflight,
  output logic    room,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t rdata
);

  result_t               slot [OBUF_DEPTH];
  logic [OBUF_PTR_W-1:0] wr_ptr, rd_ptr;
  logic [OBUF_CNT_W-1:0] count;
  logic                  pop;

  assign out_valid = count != '0;
  assign pop       = out_valid && out_ready;
  assign rdata     = slot[rd_ptr];
  // one beat may still be in the pipe ahead of the queue
  assign room = ((OBUF_CNT_W + 1)'(count) + (OBUF_CNT_W + 1)'(inflight))
              < (OBUF_CNT_W + 1)'(OBUF_DEPTH);

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == OBUF_PTR_W'(OBUF_DEPTH - 1)) ? '0 : wr_ptr + OBUF_PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == OBUF_PTR_W'(OBUF_DEPTH - 1)) ? '0 : rd_ptr + OBUF_PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + OBUF_CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - OBUF_CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= wdata;
    end
  end

endmodule

`default_nettype wire

[src/cave_automaton_generation_step_top.sv]
// Throughput: one cell per cycle; input stalls when queue fill plus the in-stage beat reaches 3.
// Result path: a cell's result is formed once the beat one row plus one cell later is accepted
//   (line memory read, then window update and rule into the output queue).
// Line memory: one entry per column, two rows deep, read and written back every beat.
// Reset (rst, synchronous): clears positions, window, queue and sets default registers;
//   the line memory is not cleared, its stale entries only reach masked neighbors.
`default_nettype none

module cave_automaton_generation_step_top
  import cave_gen_pkg::*;
#(
  parameter int MAX_ROW_LENGTH = 128,
  parameter int MAX_ROW_COUNT  = 128
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic                   cell_alive,
  input  logic                   flush,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic                   new_alive,
  output logic                   last_cell
);

  localparam int CW  = $clog2(MAX_ROW_LENGTH);
  localparam int RCW = $clog2(MAX_ROW_COUNT);
  localparam int LXW = (CW + 1 > CFG_DATA_W) ? CW + 1 : CFG_DATA_W;
  localparam int RXW = (RCW + 1 > CFG_DATA_W) ? RCW + 1 : CFG_DATA_W;
  localparam int RST_LEN_M1 =
    ((RESET_ROW_LENGTH > MAX_ROW_LENGTH) ? MAX_ROW_LENGTH : RESET_ROW_LENGTH) - 1;
  localparam int RST_ROWS_M1 =
    ((RESET_ROW_COUNT > MAX_ROW_COUNT) ? MAX_ROW_COUNT : RESET_ROW_COUNT) - 1;

  logic [THRESH_W-1:0] birth_min, death_max;
  logic [CW-1:0]       len_m1;
  logic [RCW-1:0]      rows_m1;
  logic [LXW-1:0]      len_req, len_clamp;
  logic [RXW-1:0]      rows_req, rows_clamp;
  logic                restart, take;

  logic [CW-1:0]       rd_col, s1_col, wr_addr;
  logic [1:0]          rd_data, wr_data;
  logic                wr_en, push, room;
  s1_flags_t           s1;
  result_t             res, out_res;

  always_comb begin
    len_req  = LXW'(cfg_data);
    rows_req = RXW'(cfg_data);
    if (len_req < LXW'(MIN_GEOMETRY)) begin
      len_clamp = LXW'(MIN_GEOMETRY);
    end else if (len_req > LXW'(MAX_ROW_LENGTH)) begin
      len_clamp = LXW'(MAX_ROW_LENGTH);
    end else begin
      len_clamp = len_req;
    end
    if (rows_req < RXW'(MIN_GEOMETRY)) begin
      rows_clamp = RXW'(MIN_GEOMETRY);
    end else if (rows_req > RXW'(MAX_ROW_COUNT)) begin
      rows_clamp = RXW'(MAX_ROW_COUNT);
    end else begin
      rows_clamp = rows_req;
    end
  end

  assign restart = cfg_write && ((cfg_reg_t'(cfg_index) == REG_ROW_LENGTH) ||
                                 (cfg_reg_t'(cfg_index) == REG_ROW_COUNT));

  always_ff @(posedge clk) begin
    if (rst) begin
      birth_min <= THRESH_W'(RESET_BIRTH_MIN);
      death_max <= THRESH_W'(RESET_DEATH_MAX);
      len_m1    <= CW'(RST_LEN_M1);
      rows_m1   <= RCW'(RST_ROWS_M1);
    end else if (cfg_write) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_BIRTH_MIN:  birth_min <= cfg_data[THRESH_W-1:0];
        REG_DEATH_MAX:  death_max <= cfg_data[THRESH_W-1:0];
        REG_ROW_LENGTH: len_m1    <= CW'(len_clamp - LXW'(1));
        REG_ROW_COUNT:  rows_m1   <= RCW'(rows_clamp - RXW'(1));
        default: ;
      endcase
    end
  end

  assign in_ready = room;
  assign take     = in_valid && in_ready;

  cave_gen_seq #(
    .MAX_ROW_LENGTH(MAX_ROW_LENGTH),
    .MAX_ROW_COUNT (MAX_ROW_COUNT)
  ) u_seq (
    .clk       (clk),
    .rst       (rst),
    .restart   (restart),
    .take      (take),
    .cell_alive(cell_alive),
    .flush     (flush),
    .len_m1    (len_m1),
    .rows_m1   (rows_m1),
    .rd_col    (rd_col),
    .s1_col    (s1_col),
    .s1        (s1)
  );

  cave_gen_ram #(
    .WIDTH(2),
    .DEPTH(MAX_ROW_LENGTH)
  ) u_line (
    .clk  (clk),
    .we   (wr_en),
    .waddr(wr_addr),
    .wdata(wr_data),
    .raddr(rd_col),
    .rdata(rd_data)
  );

  cave_gen_cell #(
    .MAX_ROW_LENGTH(MAX_ROW_LENGTH)
  ) u_cell (
    .clk      (clk),
    .rst      (rst),
    .restart  (restart),
    .s1       (s1),
    .s1_col   (s1_col),
    .rd_data  (rd_data),
    .birth_min(birth_min),
    .death_max(death_max),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_data  (wr_data),
    .push     (push),
    .res      (res)
  );

  cave_gen_obuf u_obuf (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .wdata    (res),
    .inflight (s1.valid),
    .room     (room),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .rdata    (out_res)
  );

  assign new_alive = out_res.new_alive;
  assign last_cell = out_res.last_cell;

endmodule

`default_nettype wire

[src/cave_gen_check.sv]
`default_nettype none

module cave_gen_check (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic new_alive,
  input logic last_cell
);

  // stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(new_alive) && $stable(last_cell))
    else $error("result beat changed while stalled");

  // input only backs up when results are waiting
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid)
    else $error("input stalled with empty output queue");

  // a result appears only after the beat that completes it is accepted and registered
  a_out_latency: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_valid && in_ready, 2))
    else $error("result without an accepted beat two cycles earlier");

  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result beat right after reset");

endmodule

bind cave_automaton_generation_step_top cave_gen_check u_check (.*);

`default_nettype wire

[tb/sv/cave_gen_checker.sv]
`timescale 1ns / 100ps

module cave_gen_checker
  import cave_gen_pkg::*;
#(
  parameter int MAX_ROW_LENGTH = 128,
  parameter int MAX_ROW_COUNT  = 128
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic                   in_valid,
  input  logic                   in_ready,
  input  logic                   cell_alive,
  input  logic                   flush,
  input  logic                   out_valid,
  input  logic                   out_ready,
  input  logic                   new_alive,
  input  logic                   last_cell,
  output int unsigned            mismatches,
  output int unsigned            outstanding
);

  // two rows of cells, even rows in the low half
  logic                  line_mem [2*MAX_ROW_LENGTH];
  // bits 6..8 left column, 3..5 center, 0..2 right; within a column bit 0 is the upper row
  logic [8:0]            window;
  int unsigned           in_pos;
  int unsigned           out_pos;
  logic [THRESH_W-1:0]   birth_min;
  logic [THRESH_W-1:0]   death_max;
  logic [CFG_DATA_W-1:0] row_length;
  logic [CFG_DATA_W-1:0] row_count;
  result_t               expected_cells [$];

  initial begin
    mismatches  = 0;
    outstanding = 0;
    foreach (line_mem[i]) line_mem[i] = 1'b0;
  end

  function automatic int unsigned clamp_dim(input int unsigned v, input int unsigned hi);
    if (v < MIN_GEOMETRY) return MIN_GEOMETRY;
    if (v > hi) return hi;
    return v;
  endfunction

  task automatic restart_generation();
    window  = '0;
    in_pos  = 0;
    out_pos = 0;
  endtask

  task automatic report_mismatch(input string what, input logic got, input logic want);
    $display("%0t: mismatch on %s: got %b, expected %b", $time, what, got, want);
    mismatches++;
  endtask

  // One accepted beat: shift the window, and once a row plus one cell is in,
  // apply the smoothing rule to the delayed cell.
  task automatic advance_grid(input logic alive_in, input logic flush_in);
    int unsigned len, rows, total, row_in, col_in, cur_base, prev_base;
    int unsigned r, c, cnt, k, j;
    logic        v, top, mid, centre;
    result_t     res;
    len   = clamp_dim(row_length, MAX_ROW_LENGTH);
    rows  = clamp_dim(row_count, MAX_ROW_COUNT);
    total = len * rows;
    v     = alive_in;
    if (in_pos < total) begin
      if (flush_in) return;  // flush before the grid is complete: dropped
    end else begin
      v = 1'b0;              // tail beat, cell value ignored
    end
    row_in    = in_pos / len;
    col_in    = in_pos % len;
    cur_base  = row_in[0] ? MAX_ROW_LENGTH : 0;
    prev_base = row_in[0] ? 0 : MAX_ROW_LENGTH;
    top = line_mem[cur_base + col_in];
    mid = line_mem[prev_base + col_in];
    line_mem[cur_base + col_in] = v;
    window = {window[5:0], v, mid, top};
    in_pos++;
    if (in_pos < len + 2) return;

    r   = out_pos / len;
    c   = out_pos % len;
    cnt = 0;
    for (k = 0; k < 3; k++) begin
      for (j = 0; j < 3; j++) begin
        if ((k == 0 && c == 0) || (k == 2 && c == len - 1)) continue;
        if ((j == 0 && r == 0) || (j == 2 && r == rows - 1)) continue;
        if (k == 1 && j == 1) continue;
        cnt += window[(2 - k) * 3 + j];
      end
    end
    centre = window[4];
    if (!centre && cnt >= birth_min) res.new_alive = 1'b1;
    else if (centre && cnt <= death_max) res.new_alive = 1'b0;
    else res.new_alive = centre;
    out_pos++;
    res.last_cell = (out_pos >= total);
    if (res.last_cell) restart_generation();
    expected_cells.push_back(res);
  endtask

  always @(posedge clk) begin : watch
    result_t want;
    if (rst) begin
      birth_min  = THRESH_W'(RESET_BIRTH_MIN);
      death_max  = THRESH_W'(RESET_DEATH_MAX);
      row_length = CFG_DATA_W'(RESET_ROW_LENGTH);
      row_count  = CFG_DATA_W'(RESET_ROW_COUNT);
      restart_generation();
      expected_cells.delete();
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          REG_BIRTH_MIN: birth_min = cfg_data[THRESH_W-1:0];
          REG_DEATH_MAX: death_max = cfg_data[THRESH_W-1:0];
          REG_ROW_LENGTH: begin
            row_length = cfg_data;
            restart_generation();
          end
          REG_ROW_COUNT: begin
            row_count = cfg_data;
            restart_generation();
          end
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        if (expected_cells.size() == 0) begin
          report_mismatch("unexpected result beat", new_alive, 1'bx);
        end else begin
          want = expected_cells.pop_front();
          if (new_alive !== want.new_alive)
            report_mismatch("new_alive", new_alive, want.new_alive);
          if (last_cell !== want.last_cell)
            report_mismatch("last_cell", last_cell, want.last_cell);
        end
      end
      if (in_valid && in_ready) advance_grid(cell_alive, flush);
    end
    outstanding <= expected_cells.size();
  end

endmodule

[tb/sv/tb.sv]
`timescale 1ns / 100ps

module tb
  import cave_gen_pkg::*;
;

  localparam int MAX_LEN       = 128;
  localparam int MAX_ROWS      = 128;
  localparam int ITEM_TARGET   = 1850;
  localparam int SETTLE_CYCLES = 8;
  localparam int HOLD_CYCLES   = 300;
  localparam int CYCLE_LIMIT   = 600000;

  logic                   clk        = 1'b0;
  logic                   rst        = 1'b1;
  logic                   cfg_write  = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index  = '0;
  logic [CFG_DATA_W-1:0]  cfg_data   = '0;
  logic                   in_valid   = 1'b0;
  logic                   cell_alive = 1'b0;
  logic                   flush      = 1'b0;
  logic                   out_ready  = 1'b0;
  logic                   in_ready;
  logic                   out_valid;
  logic                   new_alive;
  logic                   last_cell;
  int unsigned            mismatches;
  int unsigned            outstanding;

  int unsigned            cycle_count = 0;
  int unsigned            items_sent  = 0;
  int unsigned            tx_mode     = 0;
  int unsigned            hold_reqs   = 0;
  int unsigned            gen_len     = RESET_ROW_LENGTH;
  int unsigned            gen_rows    = RESET_ROW_COUNT;
  bit                     mid_gen     = 1'b0;

  always #2 clk = ~clk;

  cave_automaton_generation_step_top #(
    .MAX_ROW_LENGTH(MAX_LEN),
    .MAX_ROW_COUNT (MAX_ROWS)
  ) dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .cell_alive(cell_alive),
    .flush     (flush),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .new_alive (new_alive),
    .last_cell (last_cell)
  );

  cave_gen_checker #(
    .MAX_ROW_LENGTH(MAX_LEN),
    .MAX_ROW_COUNT (MAX_ROWS)
  ) grid_check (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .cell_alive (cell_alive),
    .flush      (flush),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .new_alive  (new_alive),
    .last_cell  (last_cell),
    .mismatches (mismatches),
    .outstanding(outstanding)
  );

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL cave_automaton_generation_step_top");
      $finish;
    end
  end

  // mode 0: no idling, 1: short gaps only, 2: short gaps and a few long ones
  function automatic int unsigned idle_len(input int unsigned mode);
    int unsigned roll;
    if (mode == 0) return 0;
    roll = $urandom_range(99);
    if (roll < 65) return 0;
    if (roll < 95 || mode == 1) return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  function automatic int unsigned fit_dim(input int unsigned v, input int unsigned hi);
    if (v < MIN_GEOMETRY) return MIN_GEOMETRY;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_threshold();
    logic [THRESH_W-1:0] thr;
    if ($urandom_range(99) < 30) begin
      case ($urandom_range(3))
        0:       thr = 4'd0;
        1:       thr = 4'd8;
        2:       thr = 4'd9;
        default: thr = 4'd15;
      endcase
    end else begin
      thr = THRESH_W'($urandom_range(8));
    end
    return {4'($urandom), thr};  // upper bits are don't-care
  endfunction

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_write <= 1'b0;
    @(posedge clk);
    if (idx == REG_ROW_LENGTH) gen_len = fit_dim(data, MAX_LEN);
    if (idx == REG_ROW_LENGTH || idx == REG_ROW_COUNT) mid_gen = 1'b0;
    if (idx == REG_ROW_COUNT) gen_rows = fit_dim(data, MAX_ROWS);
  endtask

  task automatic send_cell(input logic alive, input logic fl);
    int unsigned gap;
    gap = idle_len(tx_mode);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    cell_alive <= alive;
    flush      <= fl;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic send_seq(input logic [15:0] alive, input logic [15:0] fl, input int unsigned n);
    int unsigned k;
    for (k = 0; k < n; k++) send_cell(alive[k], fl[k]);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // One generation: cells with a little flush noise, then the tail. A cut run
  // stops partway and leaves the block mid-generation.
  task automatic run_generation(input int unsigned density, input bit cut);
    int unsigned total, n, k;
    total = gen_len * gen_rows;
    n = cut ? $urandom_range(total - 1, 1) : total;
    for (k = 0; k < n; k++) begin
      if ($urandom_range(99) < 4) send_cell(1'($urandom_range(1)), 1'b1);
      send_cell($urandom_range(99) < density, 1'b0);
      items_sent++;
    end
    if (cut) begin
      mid_gen = 1'b1;
      if ($urandom_range(1)) send_cell(1'($urandom_range(1)), 1'b1);
      return;
    end
    for (k = 0; k <= gen_len; k++) begin
      send_cell(1'($urandom_range(1)), $urandom_range(99) >= 20);
      items_sent++;
    end
    // flushes at the start of the next generation are dropped
    if ($urandom_range(9) == 0)
      repeat ($urandom_range(3, 1)) send_cell(1'($urandom_range(1)), 1'b1);
  endtask

  initial begin : drain_side
    int unsigned stall;
    int unsigned holds_served;
    int unsigned rx_mode;
    holds_served = 0;
    rx_mode      = 1;
    @(posedge clk);
    forever begin
      if (hold_reqs != holds_served) begin
        holds_served = hold_reqs;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      stall = idle_len(rx_mode);
      if (stall != 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      if ($urandom_range(63) == 0) rx_mode = $urandom_range(2);
    end
  end

  initial begin : stimulus
    int unsigned phase_no, roll, density, raw_len, raw_rows, gens;
    bit          held;
    held = 1'b0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // 2x2 grid from clamped geometry; early flush, real cell in the tail,
    // flush after the marked result
    write_reg(REG_BIRTH_MIN, 8'd3);
    write_reg(REG_DEATH_MAX, 8'd4);
    write_reg(REG_ROW_LENGTH, 8'd0);
    write_reg(REG_ROW_COUNT, 8'd1);
    write_reg(CFG_INDEX_W'($urandom_range((1 << CFG_INDEX_W) - 1, REG_ROW_COUNT + 1)),
              8'($urandom));
    send_seq(16'h003B, 16'h01C1, 9);
    wait_drained();

    // dead cells always born, live cells always die
    write_reg(REG_BIRTH_MIN, 8'd0);
    write_reg(REG_DEATH_MAX, 8'd8);
    write_reg(REG_ROW_LENGTH, 8'd3);
    write_reg(REG_ROW_COUNT, 8'd2);
    send_seq(16'h0015, 16'h03C0, 10);
    wait_drained();

    // birth threshold out of reach, full grid
    write_reg(REG_BIRTH_MIN, 8'hFF);
    write_reg(REG_DEATH_MAX, 8'hF0);
    write_reg(REG_ROW_LENGTH, 8'd2);
    send_seq(16'h007F, 16'h0070, 7);

    phase_no = 0;
    while (items_sent < ITEM_TARGET) begin
      wait_drained();
      tx_mode = $urandom_range(2);

      if (phase_no == 0) begin
        raw_len  = 255;
        raw_rows = 0;
      end else if (phase_no == 1) begin
        raw_len  = 1;
        raw_rows = 128;
      end else begin
        roll     = $urandom_range(99);
        raw_len  = $urandom_range(12, 2);
        raw_rows = $urandom_range(10, 2);
        if (roll < 3) begin
          raw_len  = $urandom_range(255, 100);
          raw_rows = $urandom_range(3);
        end else if (roll < 6) begin
          raw_rows = $urandom_range(255, 100);
          raw_len  = $urandom_range(3);
        end else if (roll < 14) begin
          raw_len  = $urandom_range(3);
          raw_rows = $urandom_range(3);
        end
      end
      if (phase_no < 2 || mid_gen || $urandom_range(1))
        write_reg(REG_ROW_LENGTH, CFG_DATA_W'(raw_len));
      if (phase_no < 2 || $urandom_range(1)) write_reg(REG_ROW_COUNT, CFG_DATA_W'(raw_rows));
      if ($urandom_range(99) < 60) write_reg(REG_BIRTH_MIN, pick_threshold());
      if ($urandom_range(99) < 60) write_reg(REG_DEATH_MAX, pick_threshold());
      if ($urandom_range(19) == 0)
        write_reg(CFG_INDEX_W'($urandom_range((1 << CFG_INDEX_W) - 1, REG_ROW_COUNT + 1)),
                  8'($urandom));

      // long output stall while cells keep coming, to back up the block
      if (!held && !mid_gen && gen_len * gen_rows >= 40) begin
        held    = 1'b1;
        tx_mode = 0;
        hold_reqs++;
      end

      gens = $urandom_range(2, 1);
      repeat (gens) begin
        roll = $urandom_range(9);
        if (roll == 0) density = 0;
        else if (roll == 1) density = 100;
        else density = $urandom_range(85, 15);
        if (!mid_gen) run_generation(density, $urandom_range(99) < 12);
      end
      phase_no++;
    end

    wait_drained();
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("PASS cave_automaton_generation_step_top");
    end else begin
      $display("FAIL cave_automaton_generation_step_top");
    end
    $finish;
  end

endmodule

[cave_automaton_generation_step_top.f]
src/cave_gen_pkg.sv
src/cave_gen_ram.sv
src/cave_gen_seq.sv
src/cave_gen_cell.sv
src/cave_gen_obuf.sv
src/cave_automaton_generation_step_top.sv
src/cave_gen_check.sv
tb/sv/cave_gen_checker.sv
tb/sv/tb.sv
